// ----- hw/rtl/ffea_pkg.sv -----
`default_nettype none
package ffea_pkg;

	localparam int MAX_EXTENTS = 16;
	localparam int IDX_W = $clog2(MAX_EXTENTS);
	localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
	localparam int ADDR_W = 32;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_MISS = 3'd1;
	localparam logic [2:0] ST_BOUNDS = 3'd2;
	localparam logic [2:0] ST_OVERLAP = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	localparam logic [ADDR_W-1:0] RESET_LENGTH = 32'd65536;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
	} ext_t;

endpackage
`default_nettype wire

// ----- hw/rtl/first_fit_extent_allocator_unit.sv -----
// First-fit extent allocator. A request (start high while busy is low) is an
// allocate or a free; exactly one result follows, shown for one cycle with done
// high, and the receiver cannot stall it; a configuration write can cut the
// request off with no result. The free extents live in a 16-entry synchronous
// memory scanned one entry at a time (issue read, then evaluate). A zero size,
// an out-of-bounds free or a free into an empty table answers in the cycle after
// the request without raising busy. Otherwise busy stays high for the scan, plus
// the moving of entries when an extent is removed or inserted by shifting; done
// rises as busy falls. After reset or a configuration write the table is rebuilt
// in the S_INIT state while busy is high.
`default_nettype none
module first_fit_extent_allocator_unit
	import ffea_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              operation,
	input  wire logic [ADDR_W-1:0] request_address,
	input  wire logic [ADDR_W-1:0] request_size,
	output logic                   done,
	output logic      [2:0]        status,
	output logic      [ADDR_W-1:0] granted_address,
	output logic      [ADDR_W-1:0] granted_size
);

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_RD, S_EVAL, S_SH_RD, S_SH_WR
	} state_t;

	state_t state_q;
	logic [ADDR_W-1:0] base_q, len_q;
	logic [CNT_W-1:0] count_q, idx_q, sh_idx_q;
	logic op_q, sh_up_q;
	logic [ADDR_W-1:0] addr_q, size_q;
	logic [ADDR_W:0] top_q;
	ext_t prev_q;
	logic [ADDR_W:0] prev_end_q;

	ext_t ext_mem_q [MAX_EXTENTS];
	ext_t rd_data_q;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic rd_en, wr_en;
	ext_t wr_data;

	logic cfg_wr;
	logic [ADDR_W-1:0] new_base, new_len, room;
	logic [ADDR_W:0] req_top, heap_end;
	logic low_ok, up_ok, low_touch, up_touch, cur_valid;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LENGTH) ? len_q : base_q;
	assign busy = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite;

	// clip the region so it ends at the top of the address space at most
	always_comb begin
		new_base = base_q;
		new_len = len_q;
		if (paddr[2] == REG_BASE) new_base = pwdata;
		else new_len = pwdata;
		room = ~new_base;
		if (new_len != '0 && (new_len - 1'b1) > room) new_len = room + 1'b1;
	end

	assign req_top = {1'b0, request_address} + {1'b0, request_size};
	assign heap_end = {1'b0, base_q} + {1'b0, len_q};

	// gap search terms for the free at position idx_q
	assign cur_valid = (state_q == S_EVAL);
	assign low_ok = (idx_q == '0) || (prev_end_q <= {1'b0, addr_q});
	assign up_ok = !cur_valid || (top_q <= {1'b0, rd_data_q.start});
	assign low_touch = (idx_q != '0) && (prev_end_q == {1'b0, addr_q});
	assign up_touch = cur_valid && ({1'b0, rd_data_q.start} == top_q);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_data_q;
		case (state_q)
			S_INIT: begin
				wr_en = 1'b1;
				wr_addr = '0;
				wr_data = '{start: base_q, length: len_q};
			end
			S_RD: begin
				rd_en = (idx_q != count_q);
			end
			S_EVAL: begin
				if (op_q == OP_ALLOC) begin
					if (rd_data_q.length > size_q) begin
						wr_en = 1'b1;
						wr_data = '{start: rd_data_q.start + size_q,
							length: rd_data_q.length - size_q};
					end
				end else if (low_ok && up_ok) begin
					if (low_touch) begin
						wr_en = 1'b1;
						wr_addr = IDX_W'(idx_q - 1'b1);
						wr_data = '{start: prev_q.start,
							length: prev_q.length + size_q
								+ (up_touch ? rd_data_q.length : '0)};
					end else if (up_touch) begin
						wr_en = 1'b1;
						wr_data = '{start: addr_q, length: rd_data_q.length + size_q};
					end
				end
			end
			S_SH_RD: begin
				if (sh_up_q) begin
					if (sh_idx_q > idx_q) begin
						rd_en = 1'b1;
						rd_addr = IDX_W'(sh_idx_q - 1'b1);
					end else begin
						wr_en = 1'b1;
						wr_data = '{start: addr_q, length: size_q};
					end
				end else if ((sh_idx_q + 1'b1) < count_q) begin
					rd_en = 1'b1;
					rd_addr = IDX_W'(sh_idx_q + 1'b1);
				end
			end
			S_SH_WR: begin
				wr_en = 1'b1;
				wr_addr = sh_idx_q[IDX_W-1:0];
			end
			default: ;
		endcase
		// last entry of a free scan is evaluated without a read
		if (state_q == S_RD && op_q == OP_FREE && idx_q == count_q && low_ok
				&& low_touch) begin
			wr_en = 1'b1;
			wr_addr = IDX_W'(idx_q - 1'b1);
			wr_data = '{start: prev_q.start, length: prev_q.length + size_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) ext_mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= ext_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			base_q <= '0;
			len_q <= RESET_LENGTH;
			count_q <= '0;
			idx_q <= '0;
			sh_idx_q <= '0;
			op_q <= OP_ALLOC;
			sh_up_q <= 1'b0;
			done <= 1'b0;
			status <= ST_OK;
			granted_address <= '0;
			granted_size <= '0;
			addr_q <= '0;
			size_q <= '0;
			top_q <= '0;
			prev_q <= '0;
			prev_end_q <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_wr) begin
				base_q <= new_base;
				len_q <= new_len;
				state_q <= S_INIT;
			end else begin
				case (state_q)
					S_INIT: begin
						count_q <= (len_q != '0) ? CNT_W'(1) : '0;
						state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (start) begin
							op_q <= operation;
							addr_q <= request_address;
							size_q <= request_size;
							top_q <= req_top;
							idx_q <= '0;
							prev_end_q <= '0;
							granted_address <= '0;
							granted_size <= '0;
							if (request_size == '0 || (operation == OP_FREE
									&& (count_q == '0 || request_address < base_q
									|| req_top > heap_end))) begin
								status <= ST_BOUNDS;
								done <= 1'b1;
							end else begin
								state_q <= S_RD;
							end
						end
					end
					S_RD: begin
						if (idx_q != count_q) begin
							state_q <= S_EVAL;
						end else if (op_q == OP_ALLOC) begin
							status <= ST_MISS;
							done <= 1'b1;
							state_q <= S_IDLE;
						end else if (!low_ok) begin
							status <= ST_OVERLAP;
							done <= 1'b1;
							state_q <= S_IDLE;
						end else if (low_touch) begin
							status <= ST_OK;
							done <= 1'b1;
							state_q <= S_IDLE;
						end else if (count_q >= CNT_W'(MAX_EXTENTS)) begin
							status <= ST_FULL;
							done <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							sh_up_q <= 1'b1;
							sh_idx_q <= count_q;
							state_q <= S_SH_RD;
						end
					end
					S_EVAL: begin
						if (op_q == OP_ALLOC) begin
							if (rd_data_q.length >= size_q) begin
								status <= ST_OK;
								granted_address <= rd_data_q.start;
								granted_size <= size_q;
								if (rd_data_q.length == size_q) begin
									sh_up_q <= 1'b0;
									sh_idx_q <= idx_q;
									state_q <= S_SH_RD;
								end else begin
									done <= 1'b1;
									state_q <= S_IDLE;
								end
							end else begin
								idx_q <= idx_q + 1'b1;
								state_q <= S_RD;
							end
						end else if (low_ok && up_ok) begin
							status <= ST_OK;
							if (low_touch && up_touch) begin
								sh_up_q <= 1'b0;
								sh_idx_q <= idx_q;
								state_q <= S_SH_RD;
							end else if (low_touch || up_touch) begin
								done <= 1'b1;
								state_q <= S_IDLE;
							end else if (count_q >= CNT_W'(MAX_EXTENTS)) begin
								status <= ST_FULL;
								done <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								sh_up_q <= 1'b1;
								sh_idx_q <= count_q;
								state_q <= S_SH_RD;
							end
						end else begin
							prev_q <= rd_data_q;
							prev_end_q <= {1'b0, rd_data_q.start} + {1'b0, rd_data_q.length};
							idx_q <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
					S_SH_RD: begin
						if (sh_up_q) begin
							if (sh_idx_q > idx_q) begin
								state_q <= S_SH_WR;
							end else begin
								count_q <= count_q + 1'b1;
								status <= ST_OK;
								done <= 1'b1;
								state_q <= S_IDLE;
							end
						end else if ((sh_idx_q + 1'b1) < count_q) begin
							state_q <= S_SH_WR;
						end else begin
							count_q <= count_q - 1'b1;
							done <= 1'b1;
							state_q <= S_IDLE;
						end
					end
					S_SH_WR: begin
						sh_idx_q <= sh_up_q ? sh_idx_q - 1'b1 : sh_idx_q + 1'b1;
						state_q <= S_SH_RD;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import ffea_pkg::*;

	class extent_scoreboard;
		logic [32:0] ext_base [MAX_EXTENTS];
		logic [32:0] ext_len [MAX_EXTENTS];
		int unsigned n_ext;
		logic [32:0] region_base;
		logic [32:0] region_len;
		logic [2:0] want_status [$];
		logic [31:0] want_addr [$];
		logic [31:0] want_size [$];
		int unsigned errors;

		function void rebuild(logic [31:0] base_v, logic [31:0] len_v);
			logic [32:0] room;
			region_base = {1'b0, base_v};
			region_len = {1'b0, len_v};
			room = 33'h0ffffffff - region_base;
			if (region_len != 0 && region_len - 1 > room)
				region_len = room + 1;
			n_ext = (region_len == 0) ? 0 : 1;
			ext_base[0] = region_base;
			ext_len[0] = region_len;
		endfunction

		function void drop_entry(int unsigned idx);
			for (int unsigned i = idx; i + 1 < n_ext; i++) begin
				ext_base[i] = ext_base[i + 1];
				ext_len[i] = ext_len[i + 1];
			end
			n_ext--;
		endfunction

		function logic [2:0] do_alloc(logic [32:0] sz, output logic [31:0] ga);
			ga = 0;
			if (sz == 0)
				return ST_BOUNDS;
			for (int unsigned i = 0; i < n_ext; i++) begin
				if (ext_len[i] >= sz) begin
					ga = ext_base[i][31:0];
					if (ext_len[i] == sz)
						drop_entry(i);
					else begin
						ext_base[i] += sz;
						ext_len[i] -= sz;
					end
					return ST_OK;
				end
			end
			return ST_MISS;
		endfunction

		function logic [2:0] do_free(logic [32:0] a, logic [32:0] sz);
			logic [33:0] top;
			int unsigned p;
			bit found, lo_t, up_t, lo_ok, up_ok;
			top = a + sz;
			found = 0;
			if (sz == 0 || n_ext == 0)
				return ST_BOUNDS;
			if (a < region_base || top > region_base + region_len)
				return ST_BOUNDS;
			for (p = 0; p <= n_ext; p++) begin
				lo_ok = (p == 0) || (ext_base[p - 1] + ext_len[p - 1] <= a);
				up_ok = (p >= n_ext) || (top <= ext_base[p]);
				if (lo_ok && up_ok) begin
					found = 1;
					break;
				end
			end
			if (!found)
				return ST_OVERLAP;
			lo_t = (p > 0) && (ext_base[p - 1] + ext_len[p - 1] == a);
			up_t = (p < n_ext) && (ext_base[p] == top);
			if (lo_t && up_t) begin
				ext_len[p - 1] += sz + ext_len[p];
				drop_entry(p);
			end else if (lo_t)
				ext_len[p - 1] += sz;
			else if (up_t) begin
				ext_base[p] = a;
				ext_len[p] += sz;
			end else begin
				if (n_ext >= MAX_EXTENTS)
					return ST_FULL;
				for (int unsigned i = n_ext; i > p; i--) begin
					ext_base[i] = ext_base[i - 1];
					ext_len[i] = ext_len[i - 1];
				end
				ext_base[p] = a;
				ext_len[p] = sz;
				n_ext++;
			end
			return ST_OK;
		endfunction

		function void note_request(logic op, logic [31:0] a, logic [31:0] sz);
			logic [2:0] st;
			logic [31:0] ga;
			ga = 0;
			if (op == OP_ALLOC)
				st = do_alloc({1'b0, sz}, ga);
			else
				st = do_free({1'b0, a}, {1'b0, sz});
			want_status.push_back(st);
			want_addr.push_back(st == ST_OK ? ga : 32'd0);
			want_size.push_back((st == ST_OK && op == OP_ALLOC) ? sz : 32'd0);
		endfunction

		function void check_result(logic [2:0] st, logic [31:0] ga, logic [31:0] gs);
			logic [2:0] es;
			logic [31:0] ea, ez;
			if (want_status.size() == 0) begin
				$error("unexpected result status=%0d", st);
				errors++;
				return;
			end
			es = want_status.pop_front();
			ea = want_addr.pop_front();
			ez = want_size.pop_front();
			if (st !== es) begin
				$error("status expected %0d actual %0d", es, st);
				errors++;
			end
			if (ga !== ea) begin
				$error("granted_address expected %h actual %h", ea, ga);
				errors++;
			end
			if (gs !== ez) begin
				$error("granted_size expected %h actual %h", ez, gs);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return want_status.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic operation = 0;
	logic [31:0] request_address = 0, request_size = 0;
	logic done;
	logic [2:0] status;
	logic [31:0] granted_address, granted_size;

	extent_scoreboard sb;
	logic [31:0] cur_base, cur_len;
	int unsigned cycles;

	first_fit_extent_allocator_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check_result(status, granted_address, granted_size);

	task automatic write_reg(logic idx, logic [31:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == REG_BASE)
			cur_base = v;
		else
			cur_len = v;
		sb.rebuild(cur_base, cur_len);
		// the block keeps the clipped length
		cur_len = sb.region_len[31:0];
		@(posedge clk);
	endtask

	task automatic wait_idle();
		start <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_request(logic op, logic [31:0] a, logic [31:0] sz, bit gap);
		int unsigned n;
		n = gap ? $urandom_range(0, 10) : 0;
		if (n != 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
		start <= 1;
		operation <= op;
		request_address <= a;
		request_size <= sz;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(op, a, sz);
	endtask

	task automatic set_heap(logic [31:0] b, logic [31:0] l);
		wait_idle();
		write_reg(REG_BASE, b);
		write_reg(REG_LENGTH, l);
	endtask

	// mostly well-formed traffic: allocations and frees of previously granted blocks
	task automatic random_phase(int n);
		logic [31:0] blk_a [$];
		logic [31:0] blk_s [$];
		logic [31:0] a, sz;
		int k, r;
		bit gap;
		for (int i = 0; i < n; i++) begin
			gap = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				sz = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, cur_len / 8 + 2);
				send_request(OP_ALLOC, $urandom(), sz, gap);
				if (sb.want_status[$] == ST_OK) begin
					blk_a.push_back(sb.want_addr[$]);
					blk_s.push_back(sz);
				end
			end else if (r < 85 && blk_a.size() > 0) begin
				k = $urandom_range(0, blk_a.size() - 1);
				a = blk_a[k];
				sz = blk_s[k];
				// split a block sometimes so the table fills
				if (sz > 1 && $urandom_range(0, 2) == 0) begin
					sz = $urandom_range(1, sz - 1);
					blk_a[k] = a + sz;
					blk_s[k] = blk_s[k] - sz;
					if ($urandom_range(0, 1)) begin
						blk_a[k] = a;
						a = a + blk_s[k];
					end
				end else begin
					blk_a.delete(k);
					blk_s.delete(k);
				end
				send_request(OP_FREE, a, sz, gap);
			end else begin
				a = ($urandom_range(0, 1)) ? $urandom() : cur_base + $urandom_range(0, cur_len);
				send_request(OP_FREE, a, $urandom_range(0, 1) ? $urandom() :
					$urandom_range(0, 64), gap);
			end
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		cur_base = 0;
		cur_len = RESET_LENGTH;
		sb.rebuild(cur_base, cur_len);
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// directed
		send_request(OP_ALLOC, 0, 0, 0);
		send_request(OP_FREE, 0, 0, 0);
		send_request(OP_ALLOC, 32'hffffffff, 32'hffffffff, 0);
		send_request(OP_ALLOC, 0, 16, 0);
		send_request(OP_ALLOC, 0, 16, 0);
		send_request(OP_ALLOC, 0, 16, 0);
		send_request(OP_FREE, 16, 16, 0);
		send_request(OP_FREE, 8, 16, 0);
		send_request(OP_FREE, 0, 16, 0);
		send_request(OP_FREE, 32, 16, 0);
		send_request(OP_FREE, 16, 16, 0);
		send_request(OP_FREE, 32'hffffffff, 1, 0);
		send_request(OP_ALLOC, 0, 65536, 0);
		send_request(OP_FREE, 0, 65536, 0);
		for (int i = 0; i < 18; i++)
			send_request(OP_FREE, 0, 0, 0);
		set_heap(0, 64);
		send_request(OP_ALLOC, 0, 64, 0);
		for (int i = 0; i < 17; i++)
			send_request(OP_FREE, i * 2 * 2, 2, 0);
		set_heap(32'hffffff00, 32'hffffffff);
		send_request(OP_ALLOC, 0, 256, 0);
		send_request(OP_FREE, 32'hffffff00, 256, 0);
		set_heap(32'h1000, 0);
		send_request(OP_ALLOC, 0, 1, 0);
		send_request(OP_FREE, 32'h1000, 1, 0);

		set_heap(0, 65536);
		random_phase(200);
		set_heap($urandom(), $urandom_range(1, 4096));
		random_phase(200);
		// sender holds off until the block has drained
		wait_idle();
		set_heap(32'hffffffff, 32'hffffffff);
		random_phase(20);
		set_heap(32'h80000000, 200);
		random_phase(200);
		set_heap($urandom(), $urandom());
		random_phase(180);

		wait_idle();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
